// ===== hdl/packet_header_classifier_core_assert.svh =====
// Assertion macros shared by the packet header classifier RTL.
`ifndef PACKET_HEADER_CLASSIFIER_CORE_ASSERT_SVH
`define PACKET_HEADER_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define PHC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PHC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define PHC_ASSERT(lbl, clk, rst_n, prop)
`define PHC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== hdl/phc_pkg.sv =====
// Package with constants and codes of the packet header classifier.
`default_nettype none
package phc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int LEN_W      = 16;
    localparam int ADDR_W     = 64;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [15:0] ETYPE_IP4 = 16'h0800;
    localparam logic [15:0] ETYPE_IP6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int ETH_HDR_LEN   = 14;
    localparam int IP4_MIN_FRAME = 34;
    localparam int IP6_MIN_FRAME = 54;
    localparam int IP4_MIN_HDR   = 20;
    localparam int UDP_HDR_LEN   = 8;
    localparam int IP6_TCP_FRAME = ETH_HDR_LEN + 60;
    localparam int IP6_UDP_FRAME = ETH_HDR_LEN + 48;

    localparam int POS_ETYPE_HI   = 12;
    localparam int POS_ETYPE_LO   = 13;
    localparam int POS_IHL        = 14;
    localparam int POS_IP6_NH     = 20;
    localparam int POS_IP4_PROTO  = 23;
    localparam int POS_IP4_SRC    = 26;
    localparam int POS_IP4_DST    = 30;
    localparam int POS_IP4_END    = 33;
    localparam int POS_IP6_SRC_HI = 22;
    localparam int POS_IP6_SRC_LO = 30;
    localparam int POS_IP6_DST_HI = 38;
    localparam int POS_IP6_DST_LO = 46;
    localparam int POS_IP6_END    = 53;

    localparam logic [1:0] NET_NONE   = 2'd0;
    localparam logic [1:0] NET_IP4    = 2'd1;
    localparam logic [1:0] NET_IP6    = 2'd2;
    localparam logic [1:0] TRANS_NONE = 2'd0;
    localparam logic [1:0] TRANS_TCP  = 2'd1;
    localparam logic [1:0] TRANS_UDP  = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/phc_if.sv =====
// Handshake interfaces for frame bytes and classification results.
`default_nettype none
interface phc_byte_if import phc_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phc_result_if import phc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              has_link_layer;
    logic [1:0]        network_kind;
    logic [1:0]        transport_kind;
    logic [1:0]        layers_found;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] src_addr_high;
    logic [ADDR_W-1:0] src_addr_low;
    logic [ADDR_W-1:0] dst_addr_high;
    logic [ADDR_W-1:0] dst_addr_low;

    modport source (
        output valid, output has_link_layer, output network_kind,
        output transport_kind, output layers_found, output frame_length,
        output src_addr_high, output src_addr_low, output dst_addr_high,
        output dst_addr_low, input ready
    );
    modport sink (
        input valid, input has_link_layer, input network_kind,
        input transport_kind, input layers_found, input frame_length,
        input src_addr_high, input src_addr_low, input dst_addr_high,
        input dst_addr_low, output ready
    );
endinterface
`default_nettype wire

// ===== hdl/packet_header_classifier_core.sv =====
// An accepted end-marked byte passes the input register, then the result register.
// Throughput: one frame byte per cycle; the input register and the header state
// update once per cycle, and only an unread result stalls an end-marked byte.
// Reset: synchronous, active low; clears the byte counter, all captured header
// fields and both valid flags, so the first accepted byte opens a new frame.
`default_nettype none
`include "packet_header_classifier_core_assert.svh"
module packet_header_classifier_core import phc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    phc_byte_if.sink      i_item,
    phc_result_if.source  o_result
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;

    logic [COUNT_BITS-1:0] r_count;
    logic [15:0]           r_ether;
    logic [3:0]            r_hw;
    logic [7:0]            r_proto;
    logic [7:0]            r_nh;
    logic [ADDR_W-1:0]     r_src_hi, r_src_lo, r_dst_hi, r_dst_lo;

    logic                  r_out_valid;
    logic                  r_link;
    logic [1:0]            r_net;
    logic [1:0]            r_trans;
    logic [1:0]            r_layers;
    logic [LEN_W-1:0]      r_len;
    logic [ADDR_W-1:0]     r_o_src_hi, r_o_src_lo, r_o_dst_hi, r_o_dst_lo;

    logic                  w_out_free;
    logic                  w_adv;

    logic [COUNT_BITS-1:0] w_pos, w_len;
    logic [15:0]           w_ether;
    logic [3:0]            w_hw;
    logic [7:0]            w_proto, w_nh;
    logic [ADDR_W-1:0]     w_src_hi, w_src_lo, w_dst_hi, w_dst_lo;
    logic                  w_is4, w_is6;
    logic [COUNT_BITS:0]   w_len_x, w_hlen;

    logic                  n_link;
    logic [1:0]            n_net, n_trans, n_layers;
    logic [ADDR_W-1:0]     n_src_hi, n_src_lo, n_dst_hi, n_dst_lo;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign i_item.ready = !r_in_valid || w_adv;

    function automatic logic in_range(input logic [COUNT_BITS-1:0] pos, input int lo,
                                      input int hi);
        in_range = (pos >= COUNT_BITS'(lo)) && (pos <= COUNT_BITS'(hi));
    endfunction

    // Field capture for the byte held in the input register.
    always_comb begin
        w_pos    = r_count;
        w_len    = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        w_ether  = r_ether;
        w_hw     = r_hw;
        w_proto  = r_proto;
        w_nh     = r_nh;
        w_src_hi = r_src_hi;
        w_src_lo = r_src_lo;
        w_dst_hi = r_dst_hi;
        w_dst_lo = r_dst_lo;
        w_is4    = (r_ether == ETYPE_IP4);
        w_is6    = (r_ether == ETYPE_IP6);
        if (w_pos == COUNT_BITS'(POS_ETYPE_HI)) begin
            w_ether = {r_in_byte, r_ether[7:0]};
        end
        if (w_pos == COUNT_BITS'(POS_ETYPE_LO)) begin
            w_ether = {r_ether[15:8], r_in_byte};
        end
        if (w_pos == COUNT_BITS'(POS_IHL)) begin
            w_hw = r_in_byte[3:0];
        end
        if (w_pos == COUNT_BITS'(POS_IP4_PROTO)) begin
            w_proto = r_in_byte;
        end
        if (w_pos == COUNT_BITS'(POS_IP6_NH)) begin
            w_nh = r_in_byte;
        end
        if (w_is4) begin
            if (in_range(w_pos, POS_IP4_SRC, POS_IP4_DST - 1)) begin
                w_src_lo = {r_src_lo[ADDR_W-9:0], r_in_byte};
            end
            if (in_range(w_pos, POS_IP4_DST, POS_IP4_END)) begin
                w_dst_lo = {r_dst_lo[ADDR_W-9:0], r_in_byte};
            end
        end else if (w_is6) begin
            if (in_range(w_pos, POS_IP6_SRC_HI, POS_IP6_SRC_LO - 1)) begin
                w_src_hi = {r_src_hi[ADDR_W-9:0], r_in_byte};
            end
            if (in_range(w_pos, POS_IP6_SRC_LO, POS_IP6_DST_HI - 1)) begin
                w_src_lo = {r_src_lo[ADDR_W-9:0], r_in_byte};
            end
            if (in_range(w_pos, POS_IP6_DST_HI, POS_IP6_DST_LO - 1)) begin
                w_dst_hi = {r_dst_hi[ADDR_W-9:0], r_in_byte};
            end
            if (in_range(w_pos, POS_IP6_DST_LO, POS_IP6_END)) begin
                w_dst_lo = {r_dst_lo[ADDR_W-9:0], r_in_byte};
            end
        end
    end

    // Classification of a completed frame from the captured fields.
    always_comb begin
        w_len_x  = {1'b0, w_len};
        w_hlen   = (COUNT_BITS + 1)'({w_hw, 2'b00});
        n_link   = (w_len >= COUNT_BITS'(ETH_HDR_LEN));
        n_net    = NET_NONE;
        n_trans  = TRANS_NONE;
        n_src_hi = '0;
        n_src_lo = '0;
        n_dst_hi = '0;
        n_dst_lo = '0;
        if (n_link && (w_ether == ETYPE_IP4) && (w_len >= COUNT_BITS'(IP4_MIN_FRAME))) begin
            n_net    = NET_IP4;
            n_src_lo = {32'd0, w_src_lo[31:0]};
            n_dst_lo = {32'd0, w_dst_lo[31:0]};
            if ((w_proto == PROTO_TCP) && (w_len_x >= w_hlen
                    + (COUNT_BITS + 1)'(ETH_HDR_LEN + IP4_MIN_HDR))) begin
                n_trans = TRANS_TCP;
            end else if ((w_proto == PROTO_UDP) && (w_len_x >= w_hlen
                    + (COUNT_BITS + 1)'(ETH_HDR_LEN + UDP_HDR_LEN))) begin
                n_trans = TRANS_UDP;
            end
        end else if (n_link && (w_ether == ETYPE_IP6)
                && (w_len >= COUNT_BITS'(IP6_MIN_FRAME))) begin
            n_net    = NET_IP6;
            n_src_hi = w_src_hi;
            n_src_lo = w_src_lo;
            n_dst_hi = w_dst_hi;
            n_dst_lo = w_dst_lo;
            if ((w_nh == PROTO_TCP) && (w_len >= COUNT_BITS'(IP6_TCP_FRAME))) begin
                n_trans = TRANS_TCP;
            end else if ((w_nh == PROTO_UDP) && (w_len >= COUNT_BITS'(IP6_UDP_FRAME))) begin
                n_trans = TRANS_UDP;
            end
        end
        n_layers = 2'(n_link) + 2'(n_net != NET_NONE) + 2'(n_trans != TRANS_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_byte <= i_item.data_byte;
            r_in_last <= i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ether  <= '0;
            r_hw     <= '0;
            r_proto  <= '0;
            r_nh     <= '0;
            r_src_hi <= '0;
            r_src_lo <= '0;
            r_dst_hi <= '0;
            r_dst_lo <= '0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_count  <= '0;
                r_ether  <= '0;
                r_hw     <= '0;
                r_proto  <= '0;
                r_nh     <= '0;
                r_src_hi <= '0;
                r_src_lo <= '0;
                r_dst_hi <= '0;
                r_dst_lo <= '0;
            end else begin
                r_count  <= w_len;
                r_ether  <= w_ether;
                r_hw     <= w_hw;
                r_proto  <= w_proto;
                r_nh     <= w_nh;
                r_src_hi <= w_src_hi;
                r_src_lo <= w_src_lo;
                r_dst_hi <= w_dst_hi;
                r_dst_lo <= w_dst_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_link     <= n_link;
            r_net      <= n_net;
            r_trans    <= n_trans;
            r_layers   <= n_layers;
            r_len      <= LEN_W'(w_len);
            r_o_src_hi <= n_src_hi;
            r_o_src_lo <= n_src_lo;
            r_o_dst_hi <= n_dst_hi;
            r_o_dst_lo <= n_dst_lo;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.has_link_layer = r_link;
    assign o_result.network_kind   = r_net;
    assign o_result.transport_kind = r_trans;
    assign o_result.layers_found   = r_layers;
    assign o_result.frame_length   = r_len;
    assign o_result.src_addr_high  = r_o_src_hi;
    assign o_result.src_addr_low   = r_o_src_lo;
    assign o_result.dst_addr_high  = r_o_dst_hi;
    assign o_result.dst_addr_low   = r_o_dst_lo;

    `PHC_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_adv && r_in_last))
    `PHC_ASSERT(a_count_cleared, i_clk, i_rst_n, (w_adv && r_in_last) |=> (r_count == '0))
    `PHC_ASSERT_NEVER(a_trans_needs_net, i_clk, i_rst_n, r_out_valid && (r_trans != TRANS_NONE) && (r_net == NET_NONE))

endmodule
`default_nettype wire
